// ----- rtl/spq_pkg.sv -----
`timescale 1ns / 1ps

package spq_pkg;

  // Default queue depth
  localparam int CAPACITY_DEF = 16;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // Input request
  typedef struct packed {
    logic               command;
    logic signed [31:0] value_in;
    logic signed [15:0] priority_in;
  } in_req_t;

  // Result
  typedef struct packed {
    logic signed [31:0] value_out;
    logic [1:0]         status;
    logic [4:0]         occupancy;
  } out_rsp_t;

  // One stored queue entry
  typedef struct packed {
    logic signed [15:0] pri;
    logic signed [31:0] val;
  } entry_t;

endpackage

// ----- rtl/spq_mem.sv -----
`timescale 1ns / 1ps

// Entry store: one write port, one read port with registered read data.
module spq_mem #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
  parameter int IDX_W    = $clog2(CAPACITY)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [IDX_W-1:0]      waddr,
  input  spq_pkg::entry_t       wdata,
  input  logic                  re,
  input  logic [IDX_W-1:0]      raddr,
  output spq_pkg::entry_t       rdata
);

  spq_pkg::entry_t mem [CAPACITY];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/sorted_priority_queue_core.sv -----
`timescale 1ns / 1ps

// Sorted priority queue core.
// Requests arrive on in_valid/in_ready/in_data: an insert places value and
// priority behind every stored entry of equal or higher priority; a delete
// returns the front entry. Each request yields one result on
// out_valid/out_ready/out_data with value, status and occupancy.
// Entries live in a single-port-write, single-port-read memory walked by a
// small sequencer with one shared priority comparator; each step is a read
// state (S_RD) followed by a compare/write state (S_CMP).
// An insert into a full queue or a delete from an empty one goes straight
// to S_DONE, and an insert into an empty queue writes the front slot at
// acceptance; any other insert scans entries from the back, plus S_WNEW if
// it lands at the front, and a delete walks every stored entry. One request
// is in work at a time and in_ready returns in the same cycle as the result
// is posted; the registered memory read sets the step.
// in_ready is high while the sequencer is idle, also while a finished
// result still waits in the output register.
// A stalled receiver holds the result; the next request may be taken but
// its result waits until the held one is accepted.
// Reset (rst_n low, synchronous) empties the queue; no clearing pass.
module sorted_priority_queue_core #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  spq_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output spq_pkg::out_rsp_t out_data
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_WNEW = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic               cmd_r, cmd_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic signed [15:0] pri_r, pri_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic signed [31:0] res_val_r, res_val_nxt;
  logic [1:0]         res_st_r, res_st_nxt;
  logic               out_valid_r, out_valid_nxt;
  spq_pkg::out_rsp_t  out_data_r, out_data_nxt;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  spq_pkg::entry_t    mem_wdata;
  logic               mem_re;
  spq_pkg::entry_t    mem_rdata;
  spq_pkg::entry_t    new_entry;

  assign new_entry = '{pri: pri_r, val: val_r};

  spq_mem #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (idx_r),
    .rdata (mem_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    val_nxt       = val_r;
    pri_nxt       = pri_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    res_val_nxt   = res_val_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = new_entry;
    mem_re        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt     = in_data.command;
          val_nxt     = in_data.value_in;
          pri_nxt     = in_data.priority_in;
          res_val_nxt = '0;
          res_st_nxt  = spq_pkg::ST_OK;
          if (in_data.command == spq_pkg::CMD_INSERT) begin
            if (cnt_r == CNT_W'(CAPACITY)) begin
              res_st_nxt = spq_pkg::ST_FULL;
              state_nxt  = S_DONE;
            end else if (cnt_r == '0) begin
              // empty queue: store straight at the front
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = '{pri: in_data.priority_in, val: in_data.value_in};
              cnt_nxt   = cnt_r + 1'b1;
              state_nxt = S_DONE;
            end else begin
              idx_nxt   = IDX_W'(cnt_r - 1'b1);
              state_nxt = S_RD;
            end
          end else begin
            if (cnt_r == '0) begin
              res_st_nxt = spq_pkg::ST_UNDERFLOW;
              state_nxt  = S_DONE;
            end else begin
              idx_nxt   = '0;
              state_nxt = S_RD;
            end
          end
        end
      end
      S_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (cmd_r == spq_pkg::CMD_INSERT) begin
          // walk from the back, moving lower-priority entries up one slot
          mem_we    = 1'b1;
          mem_waddr = idx_r + 1'b1;
          if (mem_rdata.pri < pri_r) begin
            mem_wdata = mem_rdata;
            if (idx_r == '0) begin
              state_nxt = S_WNEW;
            end else begin
              idx_nxt   = idx_r - 1'b1;
              state_nxt = S_RD;
            end
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_DONE;
          end
        end else begin
          // front entry is the result, the rest move down one slot
          if (idx_r == '0) begin
            res_val_nxt = mem_rdata.val;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = idx_r - 1'b1;
            mem_wdata = mem_rdata;
          end
          if ((CNT_W'(idx_r) + 1'b1) == cnt_r) begin
            cnt_nxt   = cnt_r - 1'b1;
            state_nxt = S_DONE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_WNEW: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hand the result over once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.value_out = res_val_r;
          out_data_nxt.status    = res_st_r;
          out_data_nxt.occupancy = 5'(cnt_r);
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    val_r      <= val_nxt;
    pri_r      <= pri_nxt;
    idx_r      <= idx_nxt;
    res_val_r  <= res_val_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sequencer idle right after a request");

  a_underflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != spq_pkg::ST_OK) |-> (out_data.value_out == '0))
    else $error("failed request returned a nonzero value");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int QDEPTH = spq_pkg::CAPACITY_DEF;
  // longest single request: a delete walking a full queue
  localparam int TAIL_CYCLES = 2 * QDEPTH + 8;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} traffic_phase_t;

  // Shadow copy of the queue plus the results it predicts
  class queue_tracker;
    int                shadow_val [QDEPTH];
    shortint           shadow_pri [QDEPTH];
    int                shadow_count;
    spq_pkg::out_rsp_t pending_results [$];
    int                errors;
    int                inserts;
    int                deletes;
    int                underflows;
    int                drops;
    int                peak;

    function new();
      shadow_count = 0;
      errors = 0;
      inserts = 0;
      deletes = 0;
      underflows = 0;
      drops = 0;
      peak = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Apply one accepted request to the shadow queue, queue its result
    function void note_request(spq_pkg::in_req_t req);
      spq_pkg::out_rsp_t want;
      int pos;
      int i;
      want = '0;
      want.status = spq_pkg::ST_OK;
      if (req.command == spq_pkg::CMD_INSERT) begin
        inserts++;
        if (shadow_count >= QDEPTH) begin
          want.status = spq_pkg::ST_FULL;
          drops++;
        end else begin
          // land behind every entry of equal or higher priority
          pos = 0;
          while (pos < shadow_count && shadow_pri[pos] >= shortint'(req.priority_in))
            pos++;
          for (i = shadow_count; i > pos; i--) begin
            shadow_val[i] = shadow_val[i-1];
            shadow_pri[i] = shadow_pri[i-1];
          end
          shadow_val[pos] = req.value_in;
          shadow_pri[pos] = req.priority_in;
          shadow_count++;
        end
      end else begin
        deletes++;
        if (shadow_count == 0) begin
          want.status = spq_pkg::ST_UNDERFLOW;
          underflows++;
        end else begin
          want.value_out = shadow_val[0];
          for (i = 1; i < shadow_count; i++) begin
            shadow_val[i-1] = shadow_val[i];
            shadow_pri[i-1] = shadow_pri[i];
          end
          shadow_count--;
        end
      end
      want.occupancy = 5'(shadow_count);
      if (shadow_count > peak)
        peak = shadow_count;
      pending_results.push_back(want);
    endfunction

    function void report(string field, logic signed [31:0] want, logic signed [31:0] got);
      errors++;
      if (errors <= 30)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(spq_pkg::out_rsp_t got);
      spq_pkg::out_rsp_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 30)
          $display("%0t: unexpected result, expected none, got value %0d status %0d occ %0d",
                   $time, got.value_out, got.status, got.occupancy);
        return;
      end
      want = pending_results.pop_front();
      if (got.value_out !== want.value_out)
        report("value_out", want.value_out, got.value_out);
      if (got.status !== want.status)
        report("status", 32'(want.status), 32'(got.status));
      if (got.occupancy !== want.occupancy)
        report("occupancy", 32'(want.occupancy), 32'(got.occupancy));
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  spq_pkg::in_req_t  in_data;
  logic              out_valid;
  logic              out_ready;
  spq_pkg::out_rsp_t out_data;

  queue_tracker tracker;
  int pressure_asked;
  int pressure_done;
  int send_calm;
  int recv_calm;

  sorted_priority_queue_core #(
    .CAPACITY(QDEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Idle length: mostly none or short, a few long; calm stretches have none
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic spq_pkg::in_req_t insert_req(logic signed [31:0] v,
                                                  logic signed [15:0] p);
    spq_pkg::in_req_t req;
    req.command = spq_pkg::CMD_INSERT;
    req.value_in = v;
    req.priority_in = p;
    return req;
  endfunction

  // delete carries junk in the ignored fields
  function automatic spq_pkg::in_req_t delete_req(logic signed [31:0] v,
                                                  logic signed [15:0] p);
    spq_pkg::in_req_t req;
    req.command = spq_pkg::CMD_DELETE;
    req.value_in = v;
    req.priority_in = p;
    return req;
  endfunction

  // Random request; priorities cluster so ties happen often
  function automatic spq_pkg::in_req_t random_req(traffic_phase_t phase);
    int ins_pct;
    int r;
    logic signed [15:0] p;
    case (phase)
      PH_FILL:  ins_pct = 80;
      PH_DRAIN: ins_pct = 20;
      default:  ins_pct = 50;
    endcase
    r = $urandom_range(0, 99);
    if (r < 45) p = 16'($urandom_range(0, 6) - 3);
    else if (r < 60) begin
      case ($urandom_range(0, 3))
        0:       p = 16'sh7FFF;
        1:       p = 16'sh8000;
        2:       p = 16'sh7FFE;
        default: p = 16'sh8001;
      endcase
    end else p = 16'($urandom);
    if ($urandom_range(0, 99) < ins_pct)
      return insert_req($urandom, p);
    return delete_req($urandom, 16'($urandom));
  endfunction

  // Offer one request and hold it until accepted; enters and leaves at a falling edge
  task automatic send_request(spq_pkg::in_req_t req);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Observe both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        tracker.check_result(out_data);
      if (in_valid && in_ready)
        tracker.note_request(in_data);
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is asked
  initial begin
    int stall_left;
    stall_left = 0;
    recv_calm = 0;
    pressure_done = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_asked != pressure_done) begin
        pressure_done++;
        stall_left = 0;
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        stall_left = pick_gap(recv_calm);
        if (stall_left > 0) begin
          stall_left--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Request side and end of run
  initial begin
    spq_pkg::in_req_t directed [$];
    traffic_phase_t phase;
    int phase_left;
    int n;
    int wait_cycles;

    tracker = new();
    pressure_asked = 0;
    send_calm = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // delete from empty, with every ignored bit set
    directed.push_back(delete_req(32'shFFFFFFFF, 16'shFFFF));
    // fill to capacity: extremes, ties, front and back landings
    directed.push_back(insert_req(32'sh7FFFFFFF, 16'sh7FFF));
    directed.push_back(insert_req(32'sh80000000, 16'sh8000));
    directed.push_back(insert_req(32'sh00000000, 16'sh0000));
    directed.push_back(insert_req(32'shFFFFFFFF, 16'sh0000));
    directed.push_back(insert_req(32'sh00000001, 16'sh0000));
    directed.push_back(insert_req(32'sh55555555, 16'sh0005));
    directed.push_back(insert_req(32'shAAAAAAAA, 16'sh0005));
    directed.push_back(insert_req(32'sh12345678, 16'shFFFF));
    directed.push_back(insert_req(32'sh00000009, 16'sh7FFF));
    directed.push_back(insert_req(32'sh0000000A, 16'sh0001));
    directed.push_back(insert_req(32'sh0000000B, 16'sh8000));
    directed.push_back(insert_req(32'sh0000000C, 16'sh0064));
    directed.push_back(insert_req(32'sh0000000D, 16'sh0000));
    directed.push_back(insert_req(32'sh0000000E, 16'shFFFF));
    directed.push_back(insert_req(32'sh0000000F, 16'sh7FFE));
    directed.push_back(insert_req(32'sh00000010, 16'sh0005));
    // full queue drops this one
    directed.push_back(insert_req(32'sh7EADBEEF, 16'sh7FFF));
    directed.push_back(delete_req(32'sh00000000, 16'sh0000));
    directed.push_back(insert_req(32'sh00000011, 16'sh7FFF));
    repeat (4) directed.push_back(delete_req($urandom, 16'($urandom)));
    foreach (directed[i])
      send_request(directed[i]);

    // Random traffic in fill / drain / mixed phases
    phase = PH_FILL;
    phase_left = 0;
    for (n = 0; n < 1200; n++) begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 2))
          0:       phase = PH_FILL;
          1:       phase = PH_DRAIN;
          default: phase = PH_MIXED;
        endcase
        phase_left = $urandom_range(10, 60);
      end
      phase_left--;
      // back up the result side while requests keep coming
      if (n == 150 || n == 700) begin
        pressure_asked++;
        send_calm = 40;
      end
      send_request(random_req(phase));
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then let any stray output show up
    while (tracker.pending() != 0) @(posedge clk);
    wait_cycles = TAIL_CYCLES;
    repeat (wait_cycles) @(posedge clk);

    $display("Ran %0d requests: %0d inserts (%0d dropped full), %0d deletes (%0d underflow).",
             tracker.inserts + tracker.deletes, tracker.inserts, tracker.drops,
             tracker.deletes, tracker.underflows);
    $display("Peak occupancy %0d of %0d, %0d receiver hold-offs, %0d mismatches.",
             tracker.peak, QDEPTH, pressure_done, tracker.errors);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/spq_pkg.sv
rtl/spq_mem.sv
rtl/sorted_priority_queue_core.sv
tb/testbench.sv
